// ===== design/tfcm_pkg.sv =====
// ----------------------------------------------------------------------------
// tfcm_pkg - shared types and constants for the thermal false color mapper
// Holds the breakpoint fractions, the divide-by-10000 reciprocal and the
// per-channel pipeline records.
// ----------------------------------------------------------------------------
package tfcm_pkg;

  // width of breakpoints, ramp numerators and denominators
  localparam int DW = 14;
  // width of scaled ramp numerator magnitude
  localparam int PW = 22;

  // channel indexes
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int NCH      = 3;

  // breakpoint fractions per 10000 of the span
  localparam int NBP = 4;
  localparam logic [13:0] BP_FRAC [NBP] = '{14'd2121, 14'd3182, 14'd4242, 14'd8182};
  localparam int BP_A = 0;
  localparam int BP_B = 1;
  localparam int BP_C = 2;
  localparam int BP_D = 3;

  // floor(x / 10000) == (x * BP_RECIP) >> BP_SHIFT for x < 2^26
  localparam logic [24:0] BP_RECIP = 25'd27487791;
  localparam int BP_SHIFT = 38;

  // ramp scales and saturation limits
  localparam logic [7:0] SCALE_RG = 8'd255;
  localparam logic [7:0] SCALE_B  = 8'd240;

  // register addresses (word select bit)
  localparam logic ADDR_SPAN_LOW  = 1'b0;
  localparam logic ADDR_SPAN_HIGH = 1'b1;

  // one ramp before division
  typedef struct packed {
    logic                 kill;   // channel forced to zero
    logic                 full;   // channel forced to its limit
    logic signed [DW-1:0] num;
    logic signed [DW-1:0] den;
    logic [7:0]           scale;
  } ramp_t;

  // one ramp during restoring division
  typedef struct packed {
    logic          kill;
    logic          full;
    logic [PW-1:0] rem;
    logic [DW-1:0] dvs;
    logic [7:0]    quo;
  } dstep_t;

endpackage

// ===== design/thermal_false_color_map.sv =====
// ----------------------------------------------------------------------------
// thermal_false_color_map - quarter-degree temperature to RGB565 false color
// Clamps the temperature, places four breakpoints in the configured span and
// builds red, green and blue from saturated piecewise ramps.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one temperature per transfer, signed 12-bit quarter degrees.
//   out_*  : one RGB565 color per transfer, in input order.
//   cfg_*  : APB-style port, span_low at 0x0, span_high at 0x4; write only
//            while no pixel is in flight.
// Throughput is one pixel per clock unless the receiver stalls. The pipeline
// has nine register stages: input capture, clamp, ramp select, magnitude and
// scale, four stages of a restoring divider (two quotient bits each, overflow
// check in the first), and saturate/pack into the output register.
// Breakpoints come from the span registers through two free-running register
// stages (multiply by fraction, multiply by reciprocal of 10000), so they
// are settled before a pixel accepted after a write reaches ramp select.
// Reset clears the valid bits and loads span_low = 72, span_high = 152.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_tready goes low; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module thermal_false_color_map
  import tfcm_pkg::*;
#(
  parameter int MAX_TEMP = 320
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [11:0] temperature, [15:12] zero
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] color
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NS = 9;

  // configuration registers
  logic signed [11:0] span_lo_r;
  logic signed [11:0] span_hi_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == ADDR_SPAN_HIGH) ? 32'(span_hi_r) : 32'(span_lo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_lo_r <= 12'sd72;
      span_hi_r <= 12'sd152;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == ADDR_SPAN_LOW) begin
        span_lo_r <= cfg_pwdata[11:0];
      end else begin
        span_hi_r <= cfg_pwdata[11:0];
      end
    end
  end

  // breakpoint computation, free running
  logic signed [12:0] span_rng;
  logic [11:0]        span_mag;
  logic [25:0]        bp_prod_r [NBP];
  logic               bp_neg_r;
  logic signed [DW-1:0] bp_r [NBP];
  logic [50:0]        bp_wide [NBP];

  assign span_rng = 13'(span_hi_r) - 13'(span_lo_r);
  assign span_mag = span_rng[12] ? 12'(-span_rng) : 12'(span_rng);

  always_comb begin
    for (int k = 0; k < NBP; k++) begin
      bp_wide[k] = 51'(bp_prod_r[k]) * 51'(BP_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    bp_neg_r <= span_rng[12];
    for (int k = 0; k < NBP; k++) begin
      bp_prod_r[k] <= 26'(span_mag) * 26'(BP_FRAC[k]);
      bp_r[k]      <= bp_neg_r ? (DW'(span_lo_r) - DW'(bp_wide[k][50:BP_SHIFT]))
                               : (DW'(span_lo_r) + DW'(bp_wide[k][50:BP_SHIFT]));
    end
  end

  // pipeline control
  logic          adv;
  logic [NS-1:0] vld_r;

  assign adv        = !vld_r[NS-1] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_tvalid};
    end
  end

  // stage registers
  logic signed [11:0]   s1_t_r;
  logic signed [DW-1:0] s2_v_r;
  ramp_t                s3_r [NCH];
  dstep_t               dv_r [5][NCH];
  logic [15:0]          out_tdata_r;

  assign out_tdata = out_tdata_r;

  // clamp
  logic signed [DW-1:0] v_nxt;
  always_comb begin
    if (s1_t_r < 12'sd0) begin
      v_nxt = '0;
    end else if (DW'(s1_t_r) > DW'(MAX_TEMP)) begin
      v_nxt = DW'(MAX_TEMP);
    end else begin
      v_nxt = DW'(s1_t_r);
    end
  end

  // ramp selection
  ramp_t                s3_nxt [NCH];
  logic signed [DW-1:0] lo_x, hi_x, v;
  always_comb begin
    lo_x = DW'(span_lo_r);
    hi_x = DW'(span_hi_r);
    v    = s2_v_r;
    // red
    s3_nxt[CH_RED] = '{kill: 1'b0, full: 1'b0, num: v - bp_r[BP_B],
                       den: bp_r[BP_C] - bp_r[BP_B], scale: SCALE_RG};
    // green
    s3_nxt[CH_GREEN] = '{kill: 1'b1, full: 1'b0, num: '0, den: '0, scale: SCALE_RG};
    if (v > lo_x && v < bp_r[BP_A]) begin
      s3_nxt[CH_GREEN].kill = 1'b0;
      s3_nxt[CH_GREEN].num  = v - lo_x;
      s3_nxt[CH_GREEN].den  = bp_r[BP_A] - lo_x;
    end else if (v >= bp_r[BP_A] && v <= bp_r[BP_C]) begin
      s3_nxt[CH_GREEN].kill = 1'b0;
      s3_nxt[CH_GREEN].full = 1'b1;
    end else if (v > bp_r[BP_C]) begin
      s3_nxt[CH_GREEN].kill = 1'b0;
      s3_nxt[CH_GREEN].num  = v - bp_r[BP_D];
      s3_nxt[CH_GREEN].den  = bp_r[BP_C] - bp_r[BP_D];
    end
    // blue
    if (v <= bp_r[BP_B]) begin
      s3_nxt[CH_BLUE] = '{kill: 1'b0, full: 1'b0, num: v - bp_r[BP_B],
                          den: bp_r[BP_A] - bp_r[BP_B], scale: SCALE_RG};
    end else if (v <= bp_r[BP_D]) begin
      s3_nxt[CH_BLUE] = '{kill: 1'b1, full: 1'b0, num: '0, den: '0, scale: SCALE_B};
    end else begin
      s3_nxt[CH_BLUE] = '{kill: 1'b0, full: 1'b0, num: v - bp_r[BP_D],
                          den: hi_x - bp_r[BP_D], scale: SCALE_B};
    end
  end

  // sign, magnitude and scale; a forced-full channel carries no ramp
  dstep_t s4_nxt [NCH];
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      s4_nxt[c].kill = s3_r[c].kill || (!s3_r[c].full && ((s3_r[c].den == '0) ||
                       ((s3_r[c].num[DW-1] ^ s3_r[c].den[DW-1]) && (s3_r[c].num != '0))));
      s4_nxt[c].full = s3_r[c].full;
      s4_nxt[c].rem  = PW'(s3_r[c].num[DW-1] ? DW'(-s3_r[c].num) : DW'(s3_r[c].num))
                       * PW'(s3_r[c].scale);
      s4_nxt[c].dvs  = s3_r[c].den[DW-1] ? DW'(-s3_r[c].den) : DW'(s3_r[c].den);
      s4_nxt[c].quo  = '0;
    end
  end

  // one restoring quotient bit
  function automatic dstep_t div_bit(dstep_t s, int b);
    logic [PW-1:0] sh;
    dstep_t        o;
    o  = s;
    sh = PW'(s.dvs) << b;
    if (s.rem >= sh) begin
      o.rem    = s.rem - sh;
      o.quo[b] = 1'b1;
    end
    return o;
  endfunction

  // divider stages, two bits each
  dstep_t dv_nxt [4][NCH];
  dstep_t ovf_chk [NCH];
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      ovf_chk[c] = dv_r[0][c];
      if (!dv_r[0][c].kill && !dv_r[0][c].full && (dv_r[0][c].rem >= {dv_r[0][c].dvs, 8'd0})) begin
        ovf_chk[c].full = 1'b1;
      end
      dv_nxt[0][c] = div_bit(div_bit(ovf_chk[c], 7), 6);
      dv_nxt[1][c] = div_bit(div_bit(dv_r[1][c], 5), 4);
      dv_nxt[2][c] = div_bit(div_bit(dv_r[2][c], 3), 2);
      dv_nxt[3][c] = div_bit(div_bit(dv_r[3][c], 1), 0);
    end
  end

  // saturate and pack
  logic [7:0]  chv [NCH];
  logic [7:0]  lim [NCH];
  logic [15:0] color_nxt;
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      lim[c] = (c == CH_BLUE) ? SCALE_B : SCALE_RG;
      if (dv_r[4][c].kill) begin
        chv[c] = '0;
      end else if (dv_r[4][c].full || dv_r[4][c].quo > lim[c]) begin
        chv[c] = lim[c];
      end else begin
        chv[c] = dv_r[4][c].quo;
      end
    end
    color_nxt = {chv[CH_RED][7:3], chv[CH_GREEN][7:2], chv[CH_BLUE][7:3]};
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_t_r      <= in_tdata[11:0];
      s2_v_r      <= v_nxt;
      s3_r        <= s3_nxt;
      dv_r[0]     <= s4_nxt;
      for (int i = 0; i < 4; i++) begin
        dv_r[i+1] <= dv_nxt[i];
      end
      out_tdata_r <= color_nxt;
    end
  end

  // blue never exceeds its limit in the packed result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:0] <= 5'(SCALE_B >> 3)))
    else $error("blue channel above saturation limit");

  // breakpoints are ordered once settled on a non-reversed span
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(span_lo_r, 2) == span_lo_r && $past(span_hi_r, 2) == span_hi_r &&
     $past(span_lo_r, 1) == span_lo_r && $past(span_hi_r, 1) == span_hi_r &&
     span_hi_r >= span_lo_r) |->
    (bp_r[BP_A] <= bp_r[BP_B] && bp_r[BP_B] <= bp_r[BP_C] && bp_r[BP_C] <= bp_r[BP_D]))
    else $error("breakpoints out of order");

  // green is never both forced full and killed at the last divider stage unless the stage before it was killed
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-2] |-> !(dv_r[4][CH_GREEN].kill && dv_r[4][CH_GREEN].full &&
                      !dv_r[3][CH_GREEN].kill))
    else $error("green flags inconsistent across divider stages");

endmodule
